// File: rtl/core/qdec_pkg.sv
// Shared types, codes and constants for the quadrature decoder with button events.
`timescale 1ns / 1ps
`default_nettype none
package qdec_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_TICK        = 2'd0;
  localparam logic [1:0] OP_READ_VALUE  = 2'd1;
  localparam logic [1:0] OP_READ_BUTTON = 2'd2;
  localparam logic [1:0] OP_CLEAR       = 2'd3;

  // Decoder modes
  localparam logic [1:0] MODE_PHASE = 2'd0;
  localparam logic [1:0] MODE_FULL  = 2'd1;

  // Button states / events
  localparam logic [2:0] BTN_OPEN     = 3'd0;
  localparam logic [2:0] BTN_HELD     = 3'd1;
  localparam logic [2:0] BTN_RELEASED = 3'd2;
  localparam logic [2:0] BTN_CLICKED  = 3'd3;
  localparam logic [2:0] BTN_DOUBLE   = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_DECODER_MODE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_NOTCH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_ENABLE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DCLICK_ENABLE   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_ENABLE     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DCLICK_WINDOW   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL    = 4'd7;

  // Acceleration
  localparam logic [11:0] ACCEL_TOP = 12'd3072;
  localparam logic [11:0] ACCEL_INC = 12'd25;
  localparam logic [11:0] ACCEL_DEC = 12'd2;

  // Button check every CHECK_INTERVAL ticks (ms)
  localparam logic [3:0] CHECK_INTERVAL = 4'd10;

  // Serial divider: one quotient bit per cycle over the 16-bit count
  localparam int unsigned DIV_BITS = 16;
  localparam logic [3:0]  DIV_LAST = 4'(DIV_BITS - 1);

  // Transition tables, 2-bit signed step per 4-bit history
  localparam logic [1:0] FULL_TAB [16] = '{
    2'b00, 2'b01, 2'b11, 2'b00, 2'b11, 2'b00, 2'b00, 2'b01,
    2'b01, 2'b00, 2'b00, 2'b11, 2'b00, 2'b11, 2'b01, 2'b00
  };
  localparam logic [1:0] HALF_TAB [16] = '{
    2'b00, 2'b00, 2'b11, 2'b00, 2'b00, 2'b00, 2'b00, 2'b01,
    2'b01, 2'b00, 2'b00, 2'b00, 2'b00, 2'b11, 2'b00, 2'b00
  };

  typedef struct packed {
    logic [1:0]  decoder_mode;
    logic [4:0]  steps_per_notch;
    logic        accel_enable;
    logic        double_click_enable;
    logic        hold_enable;
    logic [15:0] double_click_window;
    logic [15:0] hold_time;
    logic        active_level;
  } qdec_cfg_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic div_step;
    logic load_out;
  } qdec_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic read_value;
    logic div_last;
  } qdec_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/quadrature_decoder_with_button_events_top.sv
// Top level: configuration registers, output register, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Rotary quadrature decoder with button events. Each input transfer carries an
// operation and the raw pin levels. A tick (one per millisecond) samples phase A/B
// and the button, decodes steps (Gray phase difference, full or half-step
// transition table), updates the wrapping 16-bit step count and the acceleration
// level, and every tenth tick runs the click/double-click/hold classifier. A read
// value returns +/-(1 + accel/256), the accel term only with acceleration enabled,
// when at least one whole notch is pending and keeps the remainder; a read button
// returns the event and clears one-shot events; reset encoder clears count and
// acceleration. Every item produces exactly one result transfer. Flow: the
// controller takes one item per pass through its states: it captures the item at
// the accept, executes it, for read value then runs the notch division through a
// restoring divider over the 16-bit count, one quotient bit per cycle, and last
// loads the result. The next input is accepted as soon as the result sits in the
// output register, even if the sink has not taken it yet; a full output register
// stalls only the load of the following result. Configuration writes are always
// accepted (cfg_ready is tied high) and must be issued only while the block is
// idle; indexes beyond the register list are ignored.
module quadrature_decoder_with_button_events_top
  import qdec_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input items
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           operation,
  input  wire logic                 pin_a,
  input  wire logic                 pin_b,
  input  wire logic                 pin_button,
  // results
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [4:0]         step_value,
  output logic [2:0]                button_event,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  qdec_cfg_t        cfg;
  qdec_cmd_t        cmd;
  qdec_sts_t        sts;
  logic             out_free;
  logic signed [4:0] res_step;
  logic [2:0]       res_event;

  assign cfg_ready = 1'b1;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decoder_mode        <= 2'd0;
      cfg.steps_per_notch     <= 5'd4;
      cfg.accel_enable        <= 1'b1;
      cfg.double_click_enable <= 1'b1;
      cfg.hold_enable         <= 1'b1;
      cfg.double_click_window <= 16'd600;
      cfg.hold_time           <= 16'd1200;
      cfg.active_level        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DECODER_MODE:    cfg.decoder_mode        <= cfg_data[1:0];
        REG_STEPS_PER_NOTCH: cfg.steps_per_notch     <= cfg_data[4:0];
        REG_ACCEL_ENABLE:    cfg.accel_enable        <= cfg_data[0];
        REG_DCLICK_ENABLE:   cfg.double_click_enable <= cfg_data[0];
        REG_HOLD_ENABLE:     cfg.hold_enable         <= cfg_data[0];
        REG_DCLICK_WINDOW:   cfg.double_click_window <= cfg_data;
        REG_HOLD_TIME:       cfg.hold_time           <= cfg_data;
        REG_ACTIVE_LEVEL:    cfg.active_level        <= cfg_data[0];
        default: ;  // outside the register list
      endcase
    end
  end

  // Output register: the slot is free when empty or drained this cycle
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      step_value   <= res_step;
      button_event <= res_event;
    end
  end

  qdec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .out_free (out_free),
    .cmd      (cmd)
  );

  qdec_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .operation  (operation),
    .pin_a      (pin_a),
    .pin_b      (pin_b),
    .pin_button (pin_button),
    .sts        (sts),
    .res_step   (res_step),
    .res_event  (res_event)
  );

  // A result carries either a step value or a button event, never both
  a_one_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && (button_event != BTN_OPEN) |-> (step_value == 5'sd0))
    else $error("result carries both step value and button event");

  // Reported movement never exceeds 1 + 3072/256
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (step_value <= 5'sd13 && step_value >= -5'sd13))
    else $error("step value out of range");

  // Loading a result always leaves a valid result in the output register
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result load lost");

  // A result is never loaded over one the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

endmodule
`default_nettype wire

// File: rtl/core/qdec_ctrl.sv
// Controller state machine: sequences capture, execute, divide and result load.
`timescale 1ns / 1ps
`default_nettype none
module qdec_ctrl
  import qdec_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire qdec_sts_t sts,
  input  wire logic      out_free,
  output qdec_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.read_value ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

// File: rtl/core/qdec_dp.sv
// Datapath: phase decode, step count, acceleration, button classifier, notch divider.
`timescale 1ns / 1ps
`default_nettype none
module qdec_dp
  import qdec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire qdec_cfg_t   cfg,
  input  wire qdec_cmd_t   cmd,
  input  wire logic [1:0]  operation,
  input  wire logic        pin_a,
  input  wire logic        pin_b,
  input  wire logic        pin_button,
  output qdec_sts_t        sts,
  output logic signed [4:0] res_step,
  output logic [2:0]       res_event
);

  // captured item
  logic [1:0] op;
  logic       pa;
  logic       pb;
  logic       pbtn;

  // encoder / button state
  logic [3:0]  phase_history;
  logic        seeded;
  logic [15:0] step_count;
  logic [11:0] accel_level;
  logic [3:0]  check_counter;
  logic [15:0] press_time;
  logic [15:0] click_window_left;
  logic [2:0]  button_state;

  // divider
  logic [15:0] div_sh;
  logic [4:0]  div_rem;
  logic        div_neg;
  logic        div_qnz;
  logic [3:0]  div_cnt;

  // tick next values
  logic [3:0]  phase_history_next;
  logic [15:0] step_count_next;
  logic [11:0] accel_level_next;
  logic [3:0]  check_counter_next;
  logic [15:0] press_time_next;
  logic [15:0] click_window_left_next;
  logic [2:0]  button_state_next;

  always_comb begin
    logic        a_act;
    logic        b_act;
    logic        pressed;
    logic [1:0]  curr;
    logic [1:0]  diff;
    logic [1:0]  d;
    logic        moved;
    logic [3:0]  cc_inc;
    logic [15:0] elapsed;
    logic [16:0] pt_sum;

    a_act   = (pa == cfg.active_level);
    b_act   = (pb == cfg.active_level);
    pressed = (pbtn == cfg.active_level);
    elapsed = {12'd0, CHECK_INTERVAL};

    accel_level_next = accel_level;
    if (cfg.accel_enable)
      accel_level_next = (accel_level < ACCEL_DEC) ? 12'd0 : accel_level - ACCEL_DEC;

    curr  = {a_act, a_act ^ b_act};
    diff  = phase_history[1:0] - curr;
    d     = 2'b00;
    moved = 1'b0;
    phase_history_next = phase_history;
    if (!seeded) begin
      phase_history_next = (cfg.decoder_mode == MODE_PHASE) ? {2'b00, curr}
                                                            : {2'b00, a_act, b_act};
    end else if (cfg.decoder_mode == MODE_PHASE) begin
      if (diff[0]) begin
        phase_history_next = {2'b00, curr};
        d     = diff[1] ? 2'b01 : 2'b11;
        moved = 1'b1;
      end
    end else begin
      phase_history_next = {phase_history[1:0], a_act, b_act};
      d = (cfg.decoder_mode == MODE_FULL) ? FULL_TAB[phase_history_next]
                                          : HALF_TAB[phase_history_next];
      moved = (d != 2'b00);
    end
    step_count_next = step_count + {{14{d[1]}}, d};

    if (cfg.accel_enable && moved && accel_level_next <= ACCEL_TOP - ACCEL_INC)
      accel_level_next = accel_level_next + ACCEL_INC;

    // button classifier, runs every CHECK_INTERVAL ticks
    press_time_next        = press_time;
    click_window_left_next = click_window_left;
    button_state_next      = button_state;
    cc_inc                 = check_counter + 4'd1;
    check_counter_next     = cc_inc;
    pt_sum                 = {1'b0, press_time} + {1'b0, elapsed};
    if (cc_inc >= CHECK_INTERVAL) begin
      check_counter_next = 4'd0;
      if (!pressed) begin
        if (press_time > 16'd1) begin
          if (button_state == BTN_HELD) begin
            button_state_next      = BTN_RELEASED;
            click_window_left_next = 16'd0;
          end else if (click_window_left > 16'd1) begin
            if (click_window_left < cfg.double_click_window) begin
              button_state_next      = BTN_DOUBLE;
              click_window_left_next = 16'd0;
            end
          end else begin
            click_window_left_next = cfg.double_click_enable ? cfg.double_click_window
                                                             : 16'd1;
          end
        end
        press_time_next = 16'd0;
      end else begin
        if (press_time > cfg.hold_time && cfg.hold_enable)
          button_state_next = BTN_HELD;
        press_time_next = pt_sum[16] ? 16'hFFFF : pt_sum[15:0];
      end
      if (click_window_left_next != 16'd0) begin
        click_window_left_next = (click_window_left_next > elapsed)
                               ? click_window_left_next - elapsed : 16'd0;
        if (click_window_left_next == 16'd0) button_state_next = BTN_CLICKED;
      end
    end
  end

  // restoring divider step on the count magnitude
  logic [5:0]  rem_sh;
  logic [4:0]  divisor;
  logic        rem_ge;
  logic [5:0]  rem_new;
  logic [15:0] rem_ext;
  logic [4:0]  notch_mag;

  assign divisor   = (cfg.steps_per_notch == 5'd0) ? 5'd1 : cfg.steps_per_notch;
  assign rem_sh    = {div_rem, div_sh[15]};
  assign rem_ge    = (rem_sh >= {1'b0, divisor});
  assign rem_new   = rem_ge ? rem_sh - {1'b0, divisor} : rem_sh;
  assign rem_ext   = {11'd0, rem_new[4:0]};
  assign notch_mag = 5'd1 + (cfg.accel_enable ? {1'b0, accel_level[11:8]} : 5'd0);

  assign sts.read_value = (op == OP_READ_VALUE);
  assign sts.div_last   = (div_cnt == DIV_LAST);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op   <= operation;
      pa   <= pin_a;
      pb   <= pin_b;
      pbtn <= pin_button;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_history     <= '0;
      seeded            <= 1'b0;
      step_count        <= '0;
      accel_level       <= '0;
      check_counter     <= '0;
      press_time        <= '0;
      click_window_left <= '0;
      button_state      <= BTN_OPEN;
    end else if (cmd.exec) begin
      unique case (op)
        OP_TICK: begin
          phase_history     <= phase_history_next;
          seeded            <= 1'b1;
          step_count        <= step_count_next;
          accel_level       <= accel_level_next;
          check_counter     <= check_counter_next;
          press_time        <= press_time_next;
          click_window_left <= click_window_left_next;
          button_state      <= button_state_next;
        end
        OP_READ_BUTTON: begin
          if (button_state != BTN_HELD && button_state != BTN_OPEN)
            button_state <= BTN_OPEN;
        end
        OP_CLEAR: begin
          step_count  <= '0;
          accel_level <= '0;
        end
        default: ;
      endcase
    end else if (cmd.div_step && sts.div_last) begin
      // remainder keeps the sign of the count
      step_count <= div_neg ? 16'd0 - rem_ext : rem_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      div_neg   <= step_count[15];
      div_sh    <= step_count[15] ? 16'd0 - step_count : step_count;
      div_rem   <= '0;
      div_qnz   <= 1'b0;
      div_cnt   <= '0;
      res_step  <= '0;
      res_event <= (op == OP_READ_BUTTON) ? button_state : BTN_OPEN;
    end else if (cmd.div_step) begin
      div_sh  <= {div_sh[14:0], 1'b0};
      div_rem <= rem_new[4:0];
      div_qnz <= div_qnz | rem_ge;
      div_cnt <= div_cnt + 4'd1;
      if (sts.div_last) begin
        if (div_qnz || rem_ge)
          res_step <= div_neg ? 5'sd0 - $signed(notch_mag) : $signed(notch_mag);
        else
          res_step <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/quadrature_decoder_with_button_events_top_tb.sv
// Self-checking testbench for the quadrature decoder with button events.
`timescale 1ns / 1ps
module quadrature_decoder_with_button_events_top_tb;
  import qdec_pkg::*;

  // Sink hold-off: after this many results the sink stops taking results for a
  // long stretch while the source keeps offering items.
  localparam int HOLD_OFF_AT  = 400;
  localparam int HOLD_OFF_LEN = 400;
  // Watchdog: cycles with no transfer on any channel before the run is abandoned.
  localparam int STUCK_LIMIT  = 4000;
  // Random items per configuration phase, and number of random phases.
  localparam int PHASE_ITEMS  = 250;
  localparam int PHASES       = 6;
  // Long press: the button stays down well past the hold time; the encoder
  // spins over the last stretch so that the acceleration sits at its cap.
  localparam int LONG_TICKS   = 260;
  localparam int SPIN_TICKS   = 200;
  localparam int DIR_ROWS     = 19;

  localparam int FULL_STEP [16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};
  localparam int HALF_STEP [16] = '{0, 0, -1, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, -1, 0, 0};

  typedef struct packed {
    logic signed [4:0] step_value;
    logic [2:0]        button_event;
  } item_report_t;

  // Directed row: item fields, plus a result typed in where it is obvious.
  typedef struct packed {
    logic [1:0]        op;
    logic              a;
    logic              b;
    logic              btn;
    logic              given;
    logic signed [4:0] sv;
    logic [2:0]        ev;
  } dir_row_t;

  // Active level is 0 after reset, so a pin at 0 means active / pressed here.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{OP_READ_VALUE,  1'b0, 1'b0, 1'b0, 1'b1, 5'sd0, BTN_OPEN}, // count empty after reset
    '{OP_READ_BUTTON, 1'b1, 1'b1, 1'b1, 1'b1, 5'sd0, BTN_OPEN}, // no event after reset
    '{OP_TICK,        1'b1, 1'b1, 1'b1, 1'b1, 5'sd0, BTN_OPEN}, // first tick seeds phase
    '{OP_TICK,        1'b0, 1'b1, 1'b1, 1'b1, 5'sd0, BTN_OPEN}, // four steps one way
    '{OP_TICK,        1'b0, 1'b0, 1'b1, 1'b1, 5'sd0, BTN_OPEN},
    '{OP_TICK,        1'b1, 1'b0, 1'b1, 1'b1, 5'sd0, BTN_OPEN},
    '{OP_TICK,        1'b1, 1'b1, 1'b1, 1'b1, 5'sd0, BTN_OPEN},
    '{OP_READ_VALUE,  1'b0, 1'b0, 1'b0, 1'b0, 5'sd0, BTN_OPEN}, // one notch, negative
    '{OP_TICK,        1'b1, 1'b0, 1'b1, 1'b1, 5'sd0, BTN_OPEN}, // forward then back
    '{OP_TICK,        1'b1, 1'b1, 1'b1, 1'b1, 5'sd0, BTN_OPEN},
    '{OP_READ_VALUE,  1'b1, 1'b1, 1'b1, 1'b0, 5'sd0, BTN_OPEN}, // less than a notch
    '{OP_CLEAR,       1'b0, 1'b1, 1'b0, 1'b1, 5'sd0, BTN_OPEN},
    '{OP_TICK,        1'b0, 1'b1, 1'b0, 1'b1, 5'sd0, BTN_OPEN}, // button pressed
    '{OP_TICK,        1'b0, 1'b0, 1'b0, 1'b1, 5'sd0, BTN_OPEN},
    '{OP_TICK,        1'b1, 1'b0, 1'b0, 1'b1, 5'sd0, BTN_OPEN}, // tenth tick, button check
    '{OP_READ_BUTTON, 1'b0, 1'b1, 1'b1, 1'b0, 5'sd0, BTN_OPEN},
    '{OP_READ_VALUE,  1'b1, 1'b1, 1'b1, 1'b0, 5'sd0, BTN_OPEN},
    '{OP_CLEAR,       1'b1, 1'b1, 1'b1, 1'b1, 5'sd0, BTN_OPEN},
    '{OP_READ_VALUE,  1'b0, 1'b0, 1'b0, 1'b1, 5'sd0, BTN_OPEN}  // count cleared
  };

  // DUT ports, all inputs known from time zero
  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [1:0]           operation  = OP_TICK;
  logic                 pin_a      = 1'b0;
  logic                 pin_b      = 1'b0;
  logic                 pin_button = 1'b0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic signed [4:0]    step_value;
  logic [2:0]           button_event;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [15:0]          cfg_data   = '0;

  // Predictor copy of the configuration
  logic [1:0]  cfg_mode;
  logic [4:0]  cfg_spn;
  logic        cfg_accel_en;
  logic        cfg_dc_en;
  logic        cfg_hold_en;
  logic [15:0] cfg_dc_window;
  logic [15:0] cfg_hold_time;
  logic        cfg_active;

  // Predictor copy of the decoder state
  logic [3:0]  phase_hist;
  logic        phase_seeded;
  logic [15:0] step_count;
  logic [11:0] accel;
  int unsigned tick_count;
  int unsigned press_ms;
  int unsigned dc_left;
  logic [2:0]  btn_state;

  item_report_t pending_reports [$];
  int  errors       = 0;
  int  results_seen = 0;
  int  sink_stall   = 0;
  int  stuck_cycles = 0;
  bit  hold_off_done = 1'b0;
  bit  idle_on       = 1'b1;

  // Random stimulus state: encoder position, spin run, button schedule
  logic [1:0] enc_pos     = 2'd0;
  int         spin_left   = 0;
  bit         btn_pressed = 1'b0;
  int         btn_left    = 0;

  quadrature_decoder_with_button_events_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .pin_a        (pin_a),
    .pin_b        (pin_b),
    .pin_button   (pin_button),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .step_value   (step_value),
    .button_event (button_event),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void reset_model();
    cfg_mode      = MODE_PHASE;
    cfg_spn       = 5'd4;
    cfg_accel_en  = 1'b1;
    cfg_dc_en     = 1'b1;
    cfg_hold_en   = 1'b1;
    cfg_dc_window = 16'd600;
    cfg_hold_time = 16'd1200;
    cfg_active    = 1'b0;
    phase_hist    = '0;
    phase_seeded  = 1'b0;
    step_count    = '0;
    accel         = '0;
    tick_count    = 0;
    press_ms      = 0;
    dc_left       = 0;
    btn_state     = BTN_OPEN;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    case (idx)
      REG_DECODER_MODE:    cfg_mode      = data[1:0];
      REG_STEPS_PER_NOTCH: cfg_spn       = data[4:0];
      REG_ACCEL_ENABLE:    cfg_accel_en  = data[0];
      REG_DCLICK_ENABLE:   cfg_dc_en     = data[0];
      REG_HOLD_ENABLE:     cfg_hold_en   = data[0];
      REG_DCLICK_WINDOW:   cfg_dc_window = data;
      REG_HOLD_TIME:       cfg_hold_time = data;
      REG_ACTIVE_LEVEL:    cfg_active    = data[0];
      default: ;
    endcase
  endfunction

  // Button classifier, run once per CHECK_INTERVAL ticks
  function automatic void classify_button(logic pressed);
    if (!pressed) begin
      if (press_ms > 1) begin
        if (btn_state == BTN_HELD) begin
          btn_state = BTN_RELEASED;
          dc_left   = 0;
        end else if (dc_left > 1) begin
          if (dc_left < cfg_dc_window) begin
            btn_state = BTN_DOUBLE;
            dc_left   = 0;
          end
        end else begin
          dc_left = cfg_dc_en ? cfg_dc_window : 1;
        end
      end
      press_ms = 0;
    end else begin
      if (press_ms > cfg_hold_time && cfg_hold_en) btn_state = BTN_HELD;
      press_ms += CHECK_INTERVAL;
      if (press_ms > 16'hFFFF) press_ms = 16'hFFFF;
    end
    if (dc_left > 0) begin
      dc_left -= (CHECK_INTERVAL < dc_left) ? CHECK_INTERVAL : dc_left;
      if (dc_left == 0) btn_state = BTN_CLICKED;
    end
  endfunction

  function automatic item_report_t decode_item(logic [1:0] op, logic a, logic b, logic btn);
    item_report_t rep;
    logic a_act, b_act, pressed, moved;
    logic [1:0] curr, diff;
    int d, val, div, rem, q, acc;
    rep     = '0;
    a_act   = (a == cfg_active);
    b_act   = (b == cfg_active);
    pressed = (btn == cfg_active);
    moved   = 1'b0;
    d       = 0;
    case (op)
      OP_TICK: begin
        if (cfg_accel_en) accel = (accel < ACCEL_DEC) ? 12'd0 : accel - ACCEL_DEC;
        curr = (a_act ? 2'd3 : 2'd0) ^ {1'b0, b_act};
        if (!phase_seeded) begin
          phase_hist   = (cfg_mode == MODE_PHASE) ? {2'b00, curr} : {2'b00, a_act, b_act};
          phase_seeded = 1'b1;
        end else if (cfg_mode == MODE_PHASE) begin
          diff = phase_hist[1:0] - curr;
          if (diff[0]) begin
            phase_hist = {2'b00, curr};
            d          = diff[1] ? 1 : -1;
            moved      = 1'b1;
          end
        end else begin
          phase_hist = {phase_hist[1:0], a_act, b_act};
          d = (cfg_mode == MODE_FULL) ? FULL_STEP[phase_hist] : HALF_STEP[phase_hist];
          moved = (d != 0);
        end
        if (moved) step_count = step_count + 16'(d);
        if (cfg_accel_en && moved && accel <= ACCEL_TOP - ACCEL_INC) accel += ACCEL_INC;
        tick_count++;
        if (tick_count >= CHECK_INTERVAL) begin
          tick_count = 0;
          classify_button(pressed);
        end
      end
      OP_READ_VALUE: begin
        val = int'($signed(step_count));
        div = (cfg_spn == 0) ? 1 : int'(cfg_spn);
        q   = val / div;
        rem = val % div;   // truncating divide, remainder follows the count's sign
        acc = cfg_accel_en ? int'(accel >> 8) : 0;
        step_count = 16'(rem);
        if (q < 0) rep.step_value = 5'(-(1 + acc));
        else if (q > 0) rep.step_value = 5'(1 + acc);
      end
      OP_READ_BUTTON: begin
        rep.button_event = btn_state;
        if (btn_state != BTN_HELD && btn_state != BTN_OPEN) btn_state = BTN_OPEN;
      end
      default: begin
        step_count = '0;
        accel      = '0;
      end
    endcase
    return rep;
  endfunction

  function automatic logic [1:0] gray2(logic [1:0] pos);
    return {pos[1], pos[1] ^ pos[0]};
  endfunction

  // ---------------------------------------------------------------------------
  // Source side: one input transfer per call, predicted at acceptance
  // ---------------------------------------------------------------------------
  task automatic push_item(logic [1:0] op, logic a, logic b, logic btn,
                           logic given_ok, item_report_t given);
    int gap;
    item_report_t want;
    gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    pin_a      <= a;
    pin_b      <= b;
    pin_button <= btn;
    do @(posedge clk); while (!in_ready);
    want = decode_item(op, a, b, btn);
    pending_reports.push_back(given_ok ? given : want);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  // Writes every register (narrow ones with junk in the unused upper bits),
  // plus one write to an index past the register list, which must be ignored.
  task automatic write_config(logic [1:0] mode, logic [4:0] spn, logic acc, logic dc,
                              logic hold, logic [15:0] dcw, logic [15:0] ht, logic act);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(REG_DECODER_MODE,    {junk[15:2], mode});
    write_reg(REG_STEPS_PER_NOTCH, {junk[10:0], spn});
    write_reg(REG_ACCEL_ENABLE,    {junk[15:1], acc});
    write_reg(REG_DCLICK_ENABLE,   {junk[14:0], dc});
    write_reg(REG_HOLD_ENABLE,     {junk[13:0], junk[15], hold});
    write_reg(REG_DCLICK_WINDOW,   dcw);
    write_reg(REG_HOLD_TIME,       ht);
    write_reg(REG_ACTIVE_LEVEL,    {junk[12:0], junk[15:14], act});
    write_reg(CFG_IDX_W'(8 + $urandom_range(0, 7)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: quadrature steps with occasional long spins,
  // a button that is pressed and released on a schedule, reads and clears in between,
  // and some noise ticks with arbitrary pin levels.
  task automatic random_item();
    int r;
    logic [1:0] g;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      push_item(OP_READ_VALUE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0, '0);
    end else if (r < 18) begin
      push_item(OP_READ_BUTTON, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0, '0);
    end else if (r < 20) begin
      push_item(OP_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0, '0);
    end else if (r < 24) begin
      push_item(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0, '0);
    end else begin
      if (spin_left > 0) begin
        spin_left--;
        enc_pos = enc_pos + 2'd1;
      end else if ($urandom_range(0, 99) < 3) begin
        spin_left = $urandom_range(40, 180);
      end else if ($urandom_range(0, 1)) begin
        enc_pos = enc_pos + ($urandom_range(0, 1) ? 2'd1 : 2'd3);
      end
      if (btn_left == 0) begin
        btn_pressed = ~btn_pressed;
        if (btn_pressed)
          btn_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 200)
                                                 : $urandom_range(3, 30);
        else
          btn_left = $urandom_range(3, 60);
      end else begin
        btn_left--;
      end
      g = gray2(enc_pos);
      push_item(OP_TICK, g[1], g[0], btn_pressed ? cfg_active : ~cfg_active, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: random stalls, one long hold-off, and the result check
  // ---------------------------------------------------------------------------
  task automatic check_report(logic signed [4:0] sv, logic [2:0] ev);
    item_report_t want;
    if (pending_reports.size() == 0) begin
      $error("result with nothing pending: step_value %0d, button_event %0d", sv, ev);
      errors++;
    end else begin
      want = pending_reports.pop_front();
      if (sv !== want.step_value) begin
        $error("step_value: expected %0d, actual %0d", want.step_value, sv);
        errors++;
      end
      if (ev !== want.button_event) begin
        $error("button_event: expected %0d, actual %0d", want.button_event, ev);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_report(step_value, button_event);
        results_seen++;
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ready <= 1'b0;
      end else if (!hold_off_done && results_seen == HOLD_OFF_AT) begin
        // long hold-off: the output register fills and the input backs up
        hold_off_done = 1'b1;
        sink_stall    = HOLD_OFF_LEN - 1;
        out_ready    <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        sink_stall = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("quadrature_decoder_with_button_events_top_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [1:0]  mode;
    logic [4:0]  spn;
    logic        acc, dc, hold, act;
    logic [15:0] dcw, ht;
    logic [1:0]  g;
    item_report_t given;

    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset configuration
    for (int i = 0; i < DIR_ROWS; i++) begin
      given.step_value   = DIR_TAB[i].sv;
      given.button_event = DIR_TAB[i].ev;
      push_item(DIR_TAB[i].op, DIR_TAB[i].a, DIR_TAB[i].b, DIR_TAB[i].btn,
                DIR_TAB[i].given, given);
    end
    drain();

    // Random phases; the first four pin the extremes, the rest are drawn
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          mode = MODE_FULL; spn = 5'd1; acc = 1'b1; dc = 1'b1; hold = 1'b1;
          dcw = 16'd40; ht = 16'd60; act = 1'b1;
        end
        1: begin
          // half-step table, steps per notch of zero, windows at zero
          mode = 2'd2; spn = 5'd0; acc = 1'b0; dc = 1'b1; hold = 1'b1;
          dcw = 16'd0; ht = 16'd0; act = 1'b0;
        end
        2: begin
          // the unused mode code, largest divider, all timers at their top
          mode = 2'd3; spn = 5'd31; acc = 1'b1; dc = 1'b0; hold = 1'b0;
          dcw = 16'hFFFF; ht = 16'hFFFF; act = 1'b1;
        end
        3: begin
          mode = MODE_PHASE; spn = 5'd16; acc = 1'b1; dc = 1'b1; hold = 1'b1;
          dcw = 16'd100; ht = 16'd30; act = 1'b0;
        end
        default: begin
          mode = 2'($urandom_range(0, 3)); spn = 5'($urandom_range(0, 31));
          acc  = 1'($urandom_range(0, 1)); dc = 1'($urandom_range(0, 1));
          hold = 1'($urandom_range(0, 1));
          dcw  = 16'($urandom_range(0, 150)); ht = 16'($urandom_range(0, 250));
          act  = 1'($urandom_range(0, 1));
        end
      endcase
      write_config(mode, spn, acc, dc, hold, dcw, ht, act);
      repeat (PHASE_ITEMS) random_item();
      drain();
    end

    // Last part, no idling: a long press with a hold time well inside it, so
    // held is reached and survives the read, then a release.
    idle_on = 1'b0;
    act = 1'($urandom_range(0, 1));
    write_config(MODE_FULL, 5'd16, 1'b1, 1'b1, 1'b1, 16'd50, 16'd200, act);
    push_item(OP_CLEAR, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    for (int i = 0; i < LONG_TICKS; i++) begin
      if (i >= LONG_TICKS - SPIN_TICKS) enc_pos = enc_pos + 2'd1;
      g = gray2(enc_pos);
      push_item(OP_TICK, g[1], g[0], act, 1'b0, '0);
    end
    push_item(OP_READ_BUTTON, g[1], g[0], act, 1'b0, '0);   // held survives the read
    push_item(OP_READ_VALUE, g[1], g[0], act, 1'b0, '0);    // large count, top accel
    repeat (20) push_item(OP_TICK, g[1], g[0], ~act, 1'b0, '0);
    push_item(OP_READ_BUTTON, g[1], g[0], ~act, 1'b0, '0);
    push_item(OP_READ_BUTTON, g[1], g[0], ~act, 1'b0, '0);
    drain();
    repeat (30) @(posedge clk);

    if (errors == 0)
      $display("quadrature_decoder_with_button_events_top_tb: clean");
    else
      $display("quadrature_decoder_with_button_events_top_tb: errors");
    $finish;
  end

endmodule
